@@ src/itp_bracketing_root_finder_assert.svh @@
// Assertion macros for the ITP root finder.
// Included by the modules that check their own sequencing; needs i_clk and i_rst_n in scope.
`ifndef ITP_BRACKETING_ROOT_FINDER_ASSERT_SVH
`define ITP_BRACKETING_ROOT_FINDER_ASSERT_SVH

// same-cycle implication, off while in reset
`define ITP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("itp root finder: check failed");

// next-cycle implication, off while in reset
`define ITP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("itp root finder: check failed");

`endif

@@ src/itp_pkg.sv @@
// Shared types, codes and helpers for the ITP root finder.
// No dependencies; used by every other source file but the assertion header.
`default_nettype none

package itp_pkg;

    localparam int WORD_BITS = 64;
    localparam int FRAC_BITS = 32;
    localparam int Q30       = 30;

    localparam logic [6:0]        STEP_MAX = 7'd127;
    localparam logic signed [7:0] REXP_MIN = -8'sd128;

    // configuration reset values
    localparam logic [32:0] TOL_RST   = 33'd1;
    localparam logic [32:0] GAIN_RST  = 33'd858993459;
    localparam logic [33:0] POWER_RST = 34'h2_0000_0000;
    localparam logic [4:0]  SLACK_RST = 5'd1;

    // configuration register indexes
    localparam logic [1:0] CFG_TOL   = 2'd0;
    localparam logic [1:0] CFG_GAIN  = 2'd1;
    localparam logic [1:0] CFG_POWER = 2'd2;
    localparam logic [1:0] CFG_SLACK = 2'd3;

    // request operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_VALUE = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_QUERY = 2'd0;
    localparam logic [1:0] KIND_FINAL = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_ORDER = 2'd1;
    localparam logic [1:0] ERR_SIGN  = 2'd2;

    typedef struct packed {
        logic               operation;
        logic signed [63:0] lo_start;
        logic signed [63:0] hi_start;
        logic signed [63:0] f_lo_start;
        logic signed [63:0] f_hi_start;
        logic signed [63:0] f_value;
    } t_in;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [63:0] point;
        logic [6:0]         iterations;
        logic signed [63:0] lo_out;
        logic signed [63:0] hi_out;
        logic signed [63:0] f_lo_out;
        logic signed [63:0] f_hi_out;
        logic signed [63:0] f_at_root;
        logic [62:0]        precision;
        logic               precision_valid;
        logic [1:0]         error_code;
    } t_out;

    // magnitude of a two's complement word (wraps for the most negative value)
    function automatic logic [WORD_BITS-1:0] f_mag(input logic [WORD_BITS-1:0] v);
        return v[WORD_BITS-1] ? (~v + 1'b1) : v;
    endfunction

    // shift by a signed amount: right truncates, left saturates to all ones
    function automatic logic [63:0] f_shift_sat(input logic [63:0] v,
                                                input logic signed [9:0] s);
        logic [127:0] wide;
        logic [9:0]   ns;
        wide = {64'd0, v} << s[5:0];
        ns   = -s;
        if (v == 64'd0) begin
            return 64'd0;
        end else if (!s[9]) begin
            if (s >= 10'sd64 || wide[127:64] != 64'd0) return '1;
            return wide[63:0];
        end else begin
            if (s <= -10'sd64) return 64'd0;
            return v >> ns[5:0];
        end
    endfunction

endpackage

`default_nettype wire

@@ src/itp_bracketing_root_finder.sv @@
// ITP bracketing root finder, signed Q32.32. A start request with a bracket and both end
// values, and every value request while searching, gives exactly one result. Start requests
// that need no search (bad order, ends of the same sign, a zero at an end, an already narrow
// bracket) and a value request in the finishing step give their result in the cycle after
// acceptance. A start that begins a search first runs the radius count; a new ITP step runs
// the regula falsi product, the 128-step divider and 32 squarings on the shared multiplier,
// then the power product, 32 runs of the shared square-root unit for the fractional power and
// the gain product before its query. Input stall is high while the sequencer is busy and
// while an earlier result is held and the output stalls. Depends on itp_pkg, itp_mul,
// itp_div, itp_sqrt and the assertion header.
`default_nettype none

module itp_bracketing_root_finder (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire itp_pkg::t_in   i_in_req,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output itp_pkg::t_out       o_out_req,
    input  wire logic           i_cfg_we,
    input  wire logic [1:0]     i_cfg_index,
    input  wire logic [33:0]    i_cfg_data
);
    import itp_pkg::*;

    `include "itp_bracketing_root_finder_assert.svh"

    typedef enum logic [16:0] {
        S_IDLE = 17'h00001,
        S_RAD  = 17'h00002,
        S_PREP = 17'h00004,
        S_MULW = 17'h00008,
        S_DV   = 17'h00010,
        S_DVW  = 17'h00020,
        S_NORM = 17'h00040,
        S_SQ   = 17'h00080,
        S_SQW  = 17'h00100,
        S_PM   = 17'h00200,
        S_PMW  = 17'h00400,
        S_EX   = 17'h00800,
        S_EXW  = 17'h01000,
        S_GM   = 17'h02000,
        S_GMW  = 17'h04000,
        S_FIN1 = 17'h08000,
        S_FIN2 = 17'h10000
    } t_state;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_SEARCH = 3'b010,
        PH_FINISH = 3'b100
    } t_phase;

    // configuration
    logic [32:0] r_tol, r_gain;
    logic [33:0] r_pow;
    logic [4:0]  r_slack;

    // search state
    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic [63:0] r_lo, n_lo, r_hi, n_hi, r_vlo, n_vlo, r_vhi, n_vhi, r_pend, n_pend;
    logic        r_usp, n_usp;
    logic [32:0] r_rbase, n_rbase;
    logic signed [7:0] r_rexp, n_rexp;
    logic [6:0]  r_step, n_step;

    // step working registers
    logic [63:0] r_half, n_half, r_x12, n_x12, r_sum, n_sum, r_t, n_t;
    logic [63:0] r_mt, n_mt, r_nrm, n_nrm, r_delta, n_delta, r_xt, n_xt;
    logic [6:0]  r_mcnt, n_mcnt;
    logic [5:0]  r_msb, n_msb;
    logic [30:0] r_y, n_y;
    logic [31:0] r_frac, n_frac, r_ef, n_ef, r_r, n_r;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_neg, n_neg, r_sgt, n_sgt, r_slt, n_slt;
    logic signed [9:0] r_n, n_n;

    // result holding register
    t_out r_out;
    logic r_out_valid;
    t_out out_d;
    logic out_wr;

    // shared units
    logic         mul_go, mul_done, div_go, div_done, sqrt_go, sqrt_done;
    logic [63:0]  mul_a, mul_b, div_d, sqrt_x, div_q;
    logic [127:0] mul_p, div_n;
    logic [31:0]  sqrt_r;

    itp_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(mul_go), .i_a(mul_a), .i_b(mul_b),
        .o_done(mul_done), .o_prod(mul_p)
    );

    itp_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(div_go), .i_num(div_n), .i_den(div_d),
        .o_done(div_done), .o_quot(div_q)
    );

    itp_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(sqrt_go), .i_x(sqrt_x),
        .o_done(sqrt_done), .o_root(sqrt_r)
    );

    function automatic t_out mk_query(input logic [63:0] pt, input logic [6:0] it);
        t_out o;
        o            = '0;
        o.kind       = KIND_QUERY;
        o.point      = pt;
        o.iterations = it;
        return o;
    endfunction

    function automatic t_out mk_error(input logic [1:0] code);
        t_out o;
        o            = '0;
        o.kind       = KIND_ERROR;
        o.error_code = code;
        return o;
    endfunction

    function automatic t_out mk_final(input logic [63:0] pt, input logic [6:0] it,
                                      input logic [63:0] lo, input logic [63:0] hi,
                                      input logic [63:0] vlo, input logic [63:0] vhi,
                                      input logic [63:0] fx, input logic valid);
        t_out        o;
        logic [63:0] df;
        df                = hi - lo;
        o.kind            = KIND_FINAL;
        o.point           = pt;
        o.iterations      = it;
        o.lo_out          = lo;
        o.hi_out          = hi;
        o.f_lo_out        = vlo;
        o.f_hi_out        = vhi;
        o.f_at_root       = fx;
        o.precision       = valid ? df[63:1] : 63'd0;
        o.precision_valid = valid;
        o.error_code      = ERR_NONE;
        return o;
    endfunction

    // request decode and derived values
    logic        out_free, in_ready, in_acc;
    logic [33:0] twice;
    logic [63:0] in_a, in_b, in_ya, in_yb, in_y, st_w;
    logic [63:0] u_lo, u_hi, u_vlo, u_vhi, u_w, cur_w;
    logic [6:0]  u_step;
    logic [63:0] prep_w, lw, lw_mag, emag, e_val, xf, dd, xt_v, dx, fr, rk, gg, pt;
    logic [31:0] y2;
    logic [63:0] sq_v;
    logic [7:0]  rexp_m;
    logic [6:0]  mcnt_inc;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign in_ready   = (r_state == S_IDLE) && out_free;
    assign in_acc     = i_in_valid && in_ready;
    assign o_in_stall = !in_ready;
    assign twice      = {r_tol, 1'b0};

    assign in_a  = i_in_req.lo_start;
    assign in_b  = i_in_req.hi_start;
    assign in_ya = i_in_req.f_lo_start;
    assign in_yb = i_in_req.f_hi_start;
    assign in_y  = i_in_req.f_value;
    assign st_w  = in_b - in_a;

    // bracket update for a value request while searching
    always_comb begin
        u_lo  = r_lo;
        u_hi  = r_hi;
        u_vlo = r_vlo;
        u_vhi = r_vhi;
        if (in_y == 64'd0) begin
            u_lo  = r_pend;
            u_hi  = r_pend;
            u_vlo = '0;
            u_vhi = '0;
        end else if (!in_y[63] == r_usp) begin
            u_hi  = r_pend;
            u_vhi = in_y;
        end else begin
            u_lo  = r_pend;
            u_vlo = in_y;
        end
        u_w    = u_hi - u_lo;
        u_step = (r_step < STEP_MAX) ? r_step + 7'd1 : r_step;
    end

    // sequencer
    always_comb begin
        n_state = r_state;  n_phase = r_phase;
        n_lo = r_lo;  n_hi = r_hi;  n_vlo = r_vlo;  n_vhi = r_vhi;  n_pend = r_pend;
        n_usp = r_usp;  n_rbase = r_rbase;  n_rexp = r_rexp;  n_step = r_step;
        n_half = r_half;  n_x12 = r_x12;  n_sum = r_sum;  n_t = r_t;
        n_mt = r_mt;  n_nrm = r_nrm;  n_delta = r_delta;  n_xt = r_xt;
        n_mcnt = r_mcnt;  n_msb = r_msb;  n_y = r_y;  n_frac = r_frac;  n_ef = r_ef;
        n_r = r_r;  n_cnt = r_cnt;  n_neg = r_neg;  n_sgt = r_sgt;  n_slt = r_slt;
        n_n = r_n;
        out_wr = 1'b0;  out_d = '0;
        mul_go = 1'b0;  mul_a = '0;  mul_b = '0;
        div_go = 1'b0;  div_n = mul_p;  div_d = r_sum;
        sqrt_go = 1'b0;  sqrt_x = '0;
        cur_w = r_hi - r_lo;
        prep_w = cur_w;
        lw = {26'd0, r_msb, r_frac} - (64'(FRAC_BITS) << 32);
        lw_mag = f_mag(lw);
        emag = mul_p[95:32];
        e_val = r_neg ? (~emag + 64'd1) : emag;
        y2 = mul_p[61:30];
        sq_v = r_ef[r_cnt] ? {31'd0, r_r, 1'b0} : {32'd0, r_r};
        mcnt_inc = r_mcnt + 7'd1;
        rexp_m = {1'b0, r_mcnt} + {3'd0, r_slack} - 8'd1;
        xf = r_lo + r_t;
        dd = '0;  xt_v = r_x12;  dx = '0;  fr = '0;  rk = '0;  gg = '0;  pt = r_x12;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_req.operation == OP_START) begin
                        if ($signed(in_a) >= $signed(in_b)) begin
                            out_wr  = 1'b1;
                            out_d   = mk_error(ERR_ORDER);
                            n_phase = PH_IDLE;
                        end else begin
                            n_lo = in_a;  n_hi = in_b;  n_vlo = in_ya;  n_vhi = in_yb;
                            n_step = '0;
                            out_wr = 1'b1;
                            if (st_w <= {30'd0, twice}) begin
                                n_pend  = in_a + (st_w >> 1);
                                n_phase = PH_FINISH;
                                out_d   = mk_query(in_a + (st_w >> 1), 7'd0);
                            end else if (in_ya == 64'd0) begin
                                out_d   = mk_final(in_a, 7'd0, in_a, in_b, in_ya, in_yb,
                                                   64'd0, 1'b0);
                                n_phase = PH_IDLE;
                            end else if (in_yb == 64'd0) begin
                                out_d   = mk_final(in_b, 7'd0, in_a, in_b, in_ya, in_yb,
                                                   64'd0, 1'b0);
                                n_phase = PH_IDLE;
                            end else if (in_ya[63] == in_yb[63]) begin
                                out_d   = mk_error(ERR_SIGN);
                                n_phase = PH_IDLE;
                            end else begin
                                // begin a search: count the radius exponent first
                                out_wr  = 1'b0;
                                n_usp   = !in_yb[63];
                                n_rbase = r_tol;
                                n_mt    = {31'd0, r_tol};
                                n_mcnt  = '0;
                                n_phase = PH_SEARCH;
                                n_state = S_RAD;
                            end
                        end
                    end else if (r_phase == PH_FINISH) begin
                        out_wr  = 1'b1;
                        out_d   = mk_final(r_pend, r_step, r_lo, r_hi, r_vlo, r_vhi,
                                           in_y, 1'b1);
                        n_phase = PH_IDLE;
                    end else if (r_phase == PH_SEARCH) begin
                        n_lo = u_lo;  n_hi = u_hi;  n_vlo = u_vlo;  n_vhi = u_vhi;
                        n_step = u_step;
                        if (r_rexp > REXP_MIN) n_rexp = r_rexp - 8'sd1;
                        if (u_w > {30'd0, twice}) begin
                            n_state = S_PREP;
                        end else begin
                            n_pend  = u_lo + (u_w >> 1);
                            n_phase = PH_FINISH;
                            out_wr  = 1'b1;
                            out_d   = mk_query(u_lo + (u_w >> 1), u_step);
                        end
                    end
                end
            end
            // doubling count of the tolerance up to the bracket width
            S_RAD: begin
                if (r_mt != 64'd0 && r_mt < cur_w) begin
                    n_mcnt = mcnt_inc;
                    n_mt   = r_mt << 1;
                    if (r_mt[63]) begin
                        n_rexp  = {1'b0, mcnt_inc} + {3'd0, r_slack} - 8'd1;
                        n_state = S_PREP;
                    end
                end else begin
                    n_rexp  = rexp_m;
                    n_state = S_PREP;
                end
            end
            // width, midpoint, regula falsi product
            S_PREP: begin
                n_half = prep_w >> 1;
                n_x12  = r_lo + (prep_w >> 1);
                n_sum  = f_mag(r_vlo) + f_mag(r_vhi);
                n_nrm  = prep_w;
                n_msb  = 6'd63;
                if (f_mag(r_vlo) + f_mag(r_vhi) == 64'd0) begin
                    n_t     = '0;
                    n_state = S_NORM;
                end else begin
                    mul_go  = 1'b1;
                    mul_a   = prep_w;
                    mul_b   = f_mag(r_vlo);
                    n_state = S_MULW;
                end
            end
            S_MULW: if (mul_done) n_state = S_DV;
            S_DV: begin
                div_go  = 1'b1;
                n_state = S_DVW;
            end
            S_DVW: begin
                if (div_done) begin
                    n_t     = div_q;
                    n_state = S_NORM;
                end
            end
            // leading one of the width
            S_NORM: begin
                if (r_nrm[63]) begin
                    n_y     = r_nrm[63:33];
                    n_frac  = '0;
                    n_cnt   = '0;
                    n_state = S_SQ;
                end else begin
                    n_nrm = r_nrm << 1;
                    n_msb = r_msb - 6'd1;
                end
            end
            // log2 fraction by repeated squaring
            S_SQ: begin
                mul_go  = 1'b1;
                mul_a   = {33'd0, r_y};
                mul_b   = {33'd0, r_y};
                n_state = S_SQW;
            end
            S_SQW: begin
                if (mul_done) begin
                    n_frac  = {r_frac[30:0], y2[31]};
                    n_y     = y2[31] ? y2[31:1] : y2[30:0];
                    n_cnt   = r_cnt + 5'd1;
                    n_state = (r_cnt == 5'd31) ? S_PM : S_SQ;
                end
            end
            // exponent = power * (log2 w - fraction bits)
            S_PM: begin
                mul_go  = 1'b1;
                mul_a   = lw_mag;
                mul_b   = {30'd0, r_pow};
                n_neg   = lw[63];
                n_state = S_PMW;
            end
            S_PMW: begin
                if (mul_done) begin
                    n_ef    = e_val[31:0];
                    n_n     = e_val[41:32];
                    n_r     = 32'd1 << Q30;
                    n_cnt   = '0;
                    n_state = S_EX;
                end
            end
            // 2^frac by repeated square roots
            S_EX: begin
                sqrt_go = 1'b1;
                sqrt_x  = sq_v << Q30;
                n_state = S_EXW;
            end
            S_EXW: begin
                if (sqrt_done) begin
                    n_r     = sqrt_r;
                    n_cnt   = r_cnt + 5'd1;
                    n_state = (r_cnt == 5'd31) ? S_GM : S_EX;
                end
            end
            S_GM: begin
                mul_go  = 1'b1;
                mul_a   = {31'd0, r_gain};
                mul_b   = {32'd0, r_r};
                n_state = S_GMW;
            end
            S_GMW: begin
                if (mul_done) begin
                    n_delta = f_shift_sat(mul_p[63:0], r_n - 10'(Q30));
                    n_state = S_FIN1;
                end
            end
            // truncation toward the midpoint
            S_FIN1: begin
                n_sgt = $signed(r_x12) > $signed(xf);
                n_slt = $signed(r_x12) < $signed(xf);
                dd    = ($signed(r_x12) > $signed(xf)) ? r_x12 - xf : xf - r_x12;
                if (r_delta <= dd) begin
                    if ($signed(r_x12) > $signed(xf)) xt_v = xf + r_delta;
                    else if ($signed(r_x12) < $signed(xf)) xt_v = xf - r_delta;
                    else xt_v = xf;
                end
                n_xt    = xt_v;
                n_state = S_FIN2;
            end
            // projection into the radius, then the query
            S_FIN2: begin
                dx = ($signed(r_xt) >= $signed(r_x12)) ? r_xt - r_x12 : r_x12 - r_xt;
                fr = f_shift_sat({31'd0, r_rbase}, {{2{r_rexp[7]}}, r_rexp});
                rk = fr - r_half;
                gg = r_half - fr;
                if (fr >= r_half) begin
                    if (dx <= rk) pt = r_xt;
                    else if (r_sgt) pt = r_x12 - rk;
                    else if (r_slt) pt = r_x12 + rk;
                end else begin
                    if (r_sgt) pt = r_x12 + gg;
                    else if (r_slt) pt = r_x12 - gg;
                end
                if (out_free) begin
                    out_wr  = 1'b1;
                    out_d   = mk_query(pt, r_step);
                    n_pend  = pt;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol   <= TOL_RST;
            r_gain  <= GAIN_RST;
            r_pow   <= POWER_RST;
            r_slack <= SLACK_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TOL:   r_tol   <= i_cfg_data[32:0];
                CFG_GAIN:  r_gain  <= i_cfg_data[32:0];
                CFG_POWER: r_pow   <= i_cfg_data;
                CFG_SLACK: r_slack <= i_cfg_data[4:0];
                default:   r_slack <= r_slack;
            endcase
        end
    end

    // control and search state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_IDLE;
            r_out_valid <= 1'b0;
            r_lo        <= '0;
            r_hi        <= '0;
            r_vlo       <= '0;
            r_vhi       <= '0;
            r_usp       <= 1'b0;
            r_rbase     <= '0;
            r_rexp      <= '0;
            r_step      <= '0;
            r_pend      <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_lo    <= n_lo;
            r_hi    <= n_hi;
            r_vlo   <= n_vlo;
            r_vhi   <= n_vhi;
            r_usp   <= n_usp;
            r_rbase <= n_rbase;
            r_rexp  <= n_rexp;
            r_step  <= n_step;
            r_pend  <= n_pend;
            if (out_wr) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    // working registers and held result
    always_ff @(posedge i_clk) begin
        r_half  <= n_half;
        r_x12   <= n_x12;
        r_sum   <= n_sum;
        r_t     <= n_t;
        r_mt    <= n_mt;
        r_nrm   <= n_nrm;
        r_delta <= n_delta;
        r_xt    <= n_xt;
        r_mcnt  <= n_mcnt;
        r_msb   <= n_msb;
        r_y     <= n_y;
        r_frac  <= n_frac;
        r_ef    <= n_ef;
        r_r     <= n_r;
        r_cnt   <= n_cnt;
        r_neg   <= n_neg;
        r_sgt   <= n_sgt;
        r_slt   <= n_slt;
        r_n     <= n_n;
        if (out_wr) r_out <= out_d;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    // checks on sequencing
    `ITP_ASSERT_NOW(a_busy_stalls, r_state != S_IDLE, o_in_stall)
    `ITP_ASSERT_NOW(a_fin_in_search, r_state == S_FIN2, r_phase == PH_SEARCH)
    `ITP_ASSERT_NOW(a_mul_done_waited, mul_done,
        r_state == S_MULW || r_state == S_SQW || r_state == S_PMW || r_state == S_GMW)
    `ITP_ASSERT_NOW(a_div_done_waited, div_done, r_state == S_DVW)

endmodule

`default_nettype wire

@@ src/itp_mul.sv @@
// Sequenced 64 x 64 -> 128 multiplier built on one 32 x 32 product per cycle.
// Depends on itp_pkg.
`default_nettype none

module itp_mul (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_go,
    input  wire logic [63:0]    i_a,
    input  wire logic [63:0]    i_b,
    output logic                o_done,
    output logic [127:0]        o_prod
);
    import itp_pkg::*;

    logic [WORD_BITS-1:0] r_a, r_b;
    logic [127:0]         r_acc;
    logic [1:0]           r_idx;
    logic                 r_busy, r_done;
    logic [31:0]          pa, pb;
    logic [63:0]          pp;
    logic [6:0]           sh;

    // partial product for the current quarter
    always_comb begin
        pa = r_idx[1] ? r_a[63:32] : r_a[31:0];
        pb = r_idx[0] ? r_b[63:32] : r_b[31:0];
        pp = pa * pb;
        sh = {2'(r_idx[0]) + 2'(r_idx[1]), 5'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_idx  <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_idx  <= 2'd0;
                r_acc  <= '0;
                r_a    <= i_a;
                r_b    <= i_b;
            end else if (r_busy) begin
                r_acc <= r_acc + ({64'd0, pp} << sh);
                r_idx <= r_idx + 2'd1;
                if (r_idx == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

`default_nettype wire

@@ src/itp_div.sv @@
// Restoring divider, 128-bit dividend by 64-bit divisor, one quotient bit a cycle.
// Keeps the low 64 quotient bits. Depends on itp_pkg.
`default_nettype none

module itp_div (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_go,
    input  wire logic [127:0]   i_num,
    input  wire logic [63:0]    i_den,
    output logic                o_done,
    output logic [63:0]         o_quot
);
    import itp_pkg::*;

    logic [127:0]         r_num;
    logic [WORD_BITS-1:0] r_den, r_rem, r_q;
    logic [6:0]           r_cnt;
    logic                 r_busy, r_done;
    logic [64:0]          rr, rd;
    logic                 ge;

    // one shift-compare-subtract step
    always_comb begin
        rr = {r_rem, r_num[127]};
        ge = rr >= {1'b0, r_den};
        rd = rr - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 7'd0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd0;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_q    <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[126:0], 1'b0};
                r_rem <= ge ? rd[63:0] : rr[63:0];
                r_q   <= {r_q[62:0], ge};
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd127) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

`default_nettype wire

@@ src/itp_sqrt.sv @@
// Digit-by-digit floor square root of a 64-bit word, two radicand bits a cycle.
// Depends on itp_pkg.
`default_nettype none

module itp_sqrt (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_go,
    input  wire logic [63:0]    i_x,
    output logic                o_done,
    output logic [31:0]         o_root
);
    import itp_pkg::*;

    logic [WORD_BITS-1:0] r_x, r_res;
    logic [4:0]           r_cnt;
    logic                 r_busy, r_done;
    logic [5:0]           bsh;
    logic [63:0]          bitv, trial;

    always_comb begin
        bsh   = 6'd62 - {r_cnt, 1'b0};
        bitv  = 64'd1 << bsh;
        trial = r_res + bitv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
                r_x    <= i_x;
                r_res  <= '0;
            end else if (r_busy) begin
                if (r_x >= trial) begin
                    r_x   <= r_x - trial;
                    r_res <= (r_res >> 1) + bitv;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[31:0];

endmodule

`default_nettype wire
